>>> sv/env_sensor_compensation_unit_defines.svh
// Assertion macros for the compensation unit modules (used by escu_queue).
// Each macro expects clk and rst in the scope where it is used.
`ifndef ENV_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ESCU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("escu assertion failed");
`define ESCU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escu assertion failed");
`else
`define ESCU_ASSERT_IMP(lbl, ante, cons)
`define ESCU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/escu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package escu_pkg;

  localparam int DIV_W       = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MISC       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM        = 3'd4;

  localparam logic [63:0] PRESS_FINE_OFS = 64'd128000;
  localparam logic [63:0] PRESS_ADC_BASE = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE    = 64'd3125;
  localparam logic [63:0] PRESS_BIAS_47  = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HUM_FINE_OFS   = 32'd76800;
  localparam logic [31:0] HUM_MAX        = 32'd419430400;
  localparam logic [31:0] HUM_RND_LEFT   = 32'd16384;
  localparam logic [31:0] HUM_BIAS_INNER = 32'd2097152;
  localparam logic [31:0] HUM_RND_RIGHT  = 32'd8192;
  localparam logic [31:0] HUM_BIAS_H3    = 32'd32768;
  localparam logic [31:0] TEMP_RND       = 32'd128;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } coeff_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [19:0] rp;
    logic [15:0] rh;
  } front_item_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        inv;
    logic        neg;
  } side_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] r;
    r = $signed(x) >>> n;
    return r;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    logic signed [63:0] r;
    r = $signed(x) >>> n;
    return r;
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx16w(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // low 64 bits of a times a signed 16-bit coefficient
  function automatic logic [63:0] mul_s16(input logic [63:0] a, input logic [15:0] c);
    logic signed [63:0] r;
    r = $signed(a) * $signed(c);
    return r;
  endfunction

  // low 64 bits of a times an unsigned 16-bit coefficient
  function automatic logic [63:0] mul_u16(input logic [63:0] a, input logic [15:0] c);
    logic signed [63:0] r;
    r = $signed(a) * $signed({1'b0, c});
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/env_sensor_compensation_unit.sv
// Throughput: one reading per cycle unless a valid output is stalled;
// the 64-stage restoring divider sets the depth.
// A 2-entry queue separates the input stage from the compute pipeline.
// Reset (rst, synchronous) clears all valid flags and the coefficient registers.
// A stalled valid output freezes the compute pipeline; the queue absorbs the input side.
`timescale 1ns / 1ps
`default_nettype none
module env_sensor_compensation_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [escu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [escu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [19:0]                   raw_pressure,
  input  wire logic [19:0]                   raw_temperature,
  input  wire logic [15:0]                   raw_humidity,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [31:0]                 temperature_centi,
  output logic [31:0]                        pressure_q24_8,
  output logic [16:0]                        humidity_q22_10,
  output logic                               pressure_invalid
);
  import escu_pkg::*;

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [55:0] misc_coeffs;
  logic [31:0] hum_coeffs;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      misc_coeffs       <= '0;
      hum_coeffs        <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TEMP:       temp_coeffs       <= cfg_data[47:0];
        CFG_PRESS_LOW:  press_coeffs_low  <= cfg_data;
        CFG_PRESS_HIGH: press_coeffs_high <= cfg_data;
        CFG_MISC:       misc_coeffs       <= cfg_data[55:0];
        CFG_HUM:        hum_coeffs        <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  coeff_t cf;

  always_comb begin
    cf.t1 = temp_coeffs[15:0];
    cf.t2 = temp_coeffs[31:16];
    cf.t3 = temp_coeffs[47:32];
    cf.p1 = press_coeffs_low[15:0];
    cf.p2 = press_coeffs_low[31:16];
    cf.p3 = press_coeffs_low[47:32];
    cf.p4 = press_coeffs_low[63:48];
    cf.p5 = press_coeffs_high[15:0];
    cf.p6 = press_coeffs_high[31:16];
    cf.p7 = press_coeffs_high[47:32];
    cf.p8 = press_coeffs_high[63:48];
    cf.p9 = misc_coeffs[15:0];
    cf.h1 = misc_coeffs[23:16];
    cf.h2 = misc_coeffs[39:24];
    cf.h3 = misc_coeffs[47:40];
    cf.h6 = misc_coeffs[55:48];
    cf.h4 = hum_coeffs[15:0];
    cf.h5 = hum_coeffs[31:16];
  end

  logic        q_full;
  logic        push;
  logic        q_valid;
  logic        pop;
  front_item_t f_item;
  front_item_t q_item;

  escu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .raw_humidity    (raw_humidity),
    .t1              (cf.t1),
    .q_full          (q_full),
    .push            (push),
    .item            (f_item)
  );

  escu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (f_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .q_item    (q_item)
  );

  escu_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .cf                (cf),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .pressure_q24_8    (pressure_q24_8),
    .humidity_q22_10   (humidity_q22_10),
    .pressure_invalid  (pressure_invalid)
  );

endmodule
`default_nettype wire

>>> sv/escu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module escu_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [19:0]          raw_pressure,
  input  wire logic [19:0]          raw_temperature,
  input  wire logic [15:0]          raw_humidity,
  input  wire logic [15:0]          t1,
  input  wire logic                 q_full,
  output logic                      push,
  output escu_pkg::front_item_t     item
);
  import escu_pkg::*;

  logic f_valid;
  logic load;

  assign in_stall = f_valid & q_full;
  assign load     = in_valid & ~in_stall;
  assign push     = f_valid & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  // first temperature differences; raw pressure and humidity pass through
  always_ff @(posedge clk) begin
    if (load) begin
      item.a  <= {15'b0, raw_temperature[19:3]} - {15'b0, t1, 1'b0};
      item.b  <= {16'b0, raw_temperature[19:4]} - {16'b0, t1};
      item.rp <= raw_pressure;
      item.rh <= raw_humidity;
    end
  end

endmodule
`default_nettype wire

>>> sv/escu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "env_sensor_compensation_unit_defines.svh"
module escu_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire escu_pkg::front_item_t push_item,
  output logic                      full,
  output logic                      q_valid,
  input  wire logic                 pop,
  output escu_pkg::front_item_t     q_item
);
  import escu_pkg::*;

  front_item_t mem [QUEUE_DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full    = (count == 2'(QUEUE_DEPTH));
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  `ESCU_ASSERT_IMP(a_count_max, 1'b1, count <= 2'(QUEUE_DEPTH))
  `ESCU_ASSERT_IMP(a_pop_nonempty, pop, count != 2'd0)
  `ESCU_ASSERT_NXT(a_push_grows, push && !pop, count == $past(count) + 2'd1)

endmodule
`default_nettype wire

>>> sv/escu_div.sv
`timescale 1ns / 1ps
`default_nettype none
module escu_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic [63:0]       dividend,
  input  wire logic [63:0]       divisor,
  input  wire escu_pkg::side_t   side_in,
  output logic                   out_valid,
  output logic [63:0]            quotient,
  output escu_pkg::side_t        side_out
);
  import escu_pkg::*;

  logic [63:0] rem [DIV_W];
  logic [63:0] dq  [DIV_W];
  logic [63:0] dv  [DIV_W];
  side_t       sd  [DIV_W];
  logic [DIV_W-1:0] vld;

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [63:0] r_in;
    logic [63:0] d_in;
    logic [63:0] v_in;
    side_t       s_in;
    logic        vi;
    logic [64:0] trial;
    if (k == 0) begin : g_first
      assign r_in = '0;
      assign d_in = dividend;
      assign v_in = divisor;
      assign s_in = side_in;
      assign vi   = in_valid;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign d_in = dq[k-1];
      assign v_in = dv[k-1];
      assign s_in = sd[k-1];
      assign vi   = vld[k-1];
    end
    assign trial = {r_in, d_in[63]} - {1'b0, v_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!trial[64]) begin
          rem[k] <= trial[63:0];
          dq[k]  <= {d_in[62:0], 1'b1};
        end else begin
          rem[k] <= {r_in[62:0], d_in[63]};
          dq[k]  <= {d_in[62:0], 1'b0};
        end
        dv[k] <= v_in;
        sd[k] <= s_in;
      end
    end
  end

  assign out_valid = vld[DIV_W-1];
  assign quotient  = dq[DIV_W-1];
  assign side_out  = sd[DIV_W-1];

endmodule
`default_nettype wire

>>> sv/escu_back.sv
`timescale 1ns / 1ps
`default_nettype none
module escu_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire escu_pkg::front_item_t q_item,
  output logic                      pop,
  input  wire escu_pkg::coeff_t     cf,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [31:0]        temperature_centi,
  output logic [31:0]               pressure_q24_8,
  output logic [16:0]               humidity_q22_10,
  output logic                      pressure_invalid
);
  import escu_pkg::*;

  localparam int PRE_N  = 11;
  localparam int POST_N = 5;

  logic adv;
  logic [PRE_N-1:0]  vpre;
  logic [POST_N-1:0] vpost;

  assign adv = ~(out_valid & out_stall);
  assign pop = q_valid & adv;

  logic [31:0] s1_mt, s1_bb;
  logic [19:0] s1_rp, s2_rp, s3_rp, s4_rp, s5_rp, s6_rp, s7_rp, s8_rp;
  logic [15:0] s1_rh, s2_rh, s3_rh, s4_rh;
  logic [31:0] s2_v1, s2_t3p;
  logic [31:0] s3_fine;
  logic [31:0] s4_temp, s4_u;
  logic [63:0] s4_x1;
  logic [63:0] s5_xll, s5_x1p5, s5_x1p2;
  logic [31:0] s5_xhl, s5_hu5, s5_u6, s5_u3, s5_lft0, s5_temp;
  logic [63:0] s6_xsq, s6_x1p5, s6_x1p2;
  logic [31:0] s6_left, s6_inner, s6_temp;
  logic [63:0] s7_t6, s7_t3, s7_x1p5, s7_x1p2;
  logic [31:0] s7_left, s7_r0, s7_temp;
  logic [63:0] s8_x2, s8_s47;
  logic [31:0] s8_left, s8_right, s8_temp;
  logic [63:0] s9_m47, s9_n0;
  logic [31:0] s9_uu, s9_temp;
  logic [63:0] s10_x1f, s10_n;
  logic [31:0] s10_uu, s10_qq, s10_temp;
  logic [63:0] s11_ma, s11_mb;
  logic        s11_neg, s11_inv;
  logic [31:0] s11_uu, s11_hm, s11_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpre <= '0;
    end else if (adv) begin
      vpre <= {vpre[PRE_N-2:0], q_valid};
    end
  end

  // temperature and pre-division pressure / humidity
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mt <= q_item.a * sx16(cf.t2);
      s1_bb <= q_item.b * q_item.b;
      s1_rp <= q_item.rp;
      s1_rh <= q_item.rh;

      s2_v1  <= asr32(s1_mt, 11);
      s2_t3p <= asr32(s1_bb, 12) * sx16(cf.t3);
      s2_rp  <= s1_rp;
      s2_rh  <= s1_rh;

      s3_fine <= s2_v1 + asr32(s2_t3p, 14);
      s3_rp   <= s2_rp;
      s3_rh   <= s2_rh;

      s4_temp <= asr32({s3_fine[29:0], 2'b0} + s3_fine + TEMP_RND, 8);
      s4_x1   <= {{32{s3_fine[31]}}, s3_fine} - PRESS_FINE_OFS;
      s4_u    <= s3_fine - HUM_FINE_OFS;
      s4_rp   <= s3_rp;
      s4_rh   <= s3_rh;

      s5_xll  <= {32'b0, s4_x1[31:0]} * {32'b0, s4_x1[31:0]};
      s5_xhl  <= s4_x1[63:32] * s4_x1[31:0];
      s5_x1p5 <= mul_s16(s4_x1, cf.p5);
      s5_x1p2 <= mul_s16(s4_x1, cf.p2);
      s5_hu5  <= sx16(cf.h5) * s4_u;
      s5_u6   <= s4_u * sx8(cf.h6);
      s5_u3   <= s4_u * {24'b0, cf.h3};
      s5_lft0 <= {2'b0, s4_rh, 14'b0} - {cf.h4[11:0], 20'b0} + HUM_RND_LEFT;
      s5_temp <= s4_temp;
      s5_rp   <= s4_rp;

      s6_xsq   <= s5_xll + {s5_xhl[30:0], 33'b0};
      s6_x1p5  <= s5_x1p5;
      s6_x1p2  <= s5_x1p2;
      s6_left  <= asr32(s5_lft0 - s5_hu5, 15);
      s6_inner <= asr32(s5_u6, 10) * (asr32(s5_u3, 11) + HUM_BIAS_H3);
      s6_temp  <= s5_temp;
      s6_rp    <= s5_rp;

      s7_t6   <= mul_s16(s6_xsq, cf.p6);
      s7_t3   <= mul_s16(s6_xsq, cf.p3);
      s7_x1p5 <= s6_x1p5;
      s7_x1p2 <= s6_x1p2;
      s7_left <= s6_left;
      s7_r0   <= (asr32(s6_inner, 10) + HUM_BIAS_INNER) * sx16(cf.h2);
      s7_temp <= s6_temp;
      s7_rp   <= s6_rp;

      s8_x2    <= s7_t6 + (s7_x1p5 << 17) + (sx16w(cf.p4) << 35);
      s8_s47   <= PRESS_BIAS_47 + asr64(s7_t3, 8) + (s7_x1p2 << 12);
      s8_left  <= s7_left;
      s8_right <= asr32(s7_r0 + HUM_RND_RIGHT, 14);
      s8_temp  <= s7_temp;
      s8_rp    <= s7_rp;

      s9_m47  <= mul_u16(s8_s47, cf.p1);
      s9_n0   <= ((PRESS_ADC_BASE - {44'b0, s8_rp}) << 31) - s8_x2;
      s9_uu   <= s8_left * s8_right;
      s9_temp <= s8_temp;

      s10_x1f  <= asr64(s9_m47, 33);
      s10_n    <= s9_n0 * PRESS_SCALE;
      s10_qq   <= asr32(s9_uu, 15) * asr32(s9_uu, 15);
      s10_uu   <= s9_uu;
      s10_temp <= s9_temp;

      s11_ma   <= s10_n[63] ? (64'd0 - s10_n) : s10_n;
      s11_mb   <= s10_x1f[63] ? (64'd0 - s10_x1f) : s10_x1f;
      s11_neg  <= s10_n[63] ^ s10_x1f[63];
      s11_inv  <= (s10_x1f == 64'd0);
      s11_hm   <= asr32(s10_qq, 7) * {24'b0, cf.h1};
      s11_uu   <= s10_uu;
      s11_temp <= s10_temp;
    end
  end

  // humidity finish: clamp to range, then drop 12 fraction bits
  logic [31:0] hv;
  logic [31:0] hc;
  side_t       div_side_in;

  always_comb begin
    hv = s11_uu - asr32(s11_hm, 4);
    priority if (hv[31]) begin
      hc = 32'd0;
    end else if (hv > HUM_MAX) begin
      hc = HUM_MAX;
    end else begin
      hc = hv;
    end
    div_side_in.temp = s11_temp;
    div_side_in.hum  = hc[28:12];
    div_side_in.inv  = s11_inv;
    div_side_in.neg  = s11_neg;
  end

  logic        div_valid;
  logic [63:0] div_q;
  side_t       div_side;

  escu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vpre[PRE_N-1]),
    .dividend  (s11_ma),
    .divisor   (s11_mb),
    .side_in   (div_side_in),
    .out_valid (div_valid),
    .quotient  (div_q),
    .side_out  (div_side)
  );

  logic [63:0] pa_p;
  logic [63:0] pb_ll, pb_y2m, pb_p;
  logic [31:0] pb_hl;
  logic [63:0] pc_ss, pc_y2m, pc_p;
  logic [63:0] pd_y1m, pd_y2m, pd_p;
  logic [63:0] pe_psum;
  side_t       pa_sd, pb_sd, pc_sd, pd_sd, pe_sd;
  logic [63:0] pa_s;
  logic [63:0] pres;

  assign pa_s = asr64(pa_p, 13);
  assign pres = asr64(pe_psum, 8) + (sx16w(cf.p7) << 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vpost     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vpost     <= {vpost[POST_N-2:0], div_valid};
      out_valid <= vpost[POST_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_p  <= div_side.neg ? (64'd0 - div_q) : div_q;
      pa_sd <= div_side;

      pb_ll  <= {32'b0, pa_s[31:0]} * {32'b0, pa_s[31:0]};
      pb_hl  <= pa_s[63:32] * pa_s[31:0];
      pb_y2m <= mul_s16(pa_p, cf.p8);
      pb_p   <= pa_p;
      pb_sd  <= pa_sd;

      pc_ss  <= pb_ll + {pb_hl[30:0], 33'b0};
      pc_y2m <= pb_y2m;
      pc_p   <= pb_p;
      pc_sd  <= pb_sd;

      pd_y1m <= mul_s16(pc_ss, cf.p9);
      pd_y2m <= pc_y2m;
      pd_p   <= pc_p;
      pd_sd  <= pc_sd;

      pe_psum <= pd_p + asr64(pd_y1m, 25) + asr64(pd_y2m, 19);
      pe_sd   <= pd_sd;

      temperature_centi <= $signed(pe_sd.temp);
      pressure_q24_8    <= pe_sd.inv ? 32'd0 : pres[31:0];
      humidity_q22_10   <= pe_sd.hum;
      pressure_invalid  <= pe_sd.inv;
    end
  end

endmodule
`default_nettype wire

>>> tb/env_sensor_compensation_unit_test.sv
`timescale 1ns / 1ps
module env_sensor_compensation_unit_test;
  import escu_pkg::*;

  typedef struct {
    logic [19:0] p;
    logic [19:0] t;
    logic [15:0] h;
  } reading_t;

  typedef struct {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
    logic        inv;
  } comp_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [19:0] raw_pressure = '0;
  logic [19:0] raw_temperature = '0;
  logic [15:0] raw_humidity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic [16:0] humidity_q22_10;
  logic pressure_invalid;

  logic [63:0] k_temp, k_plow, k_phigh, k_misc, k_hum;
  reading_t pending[$];
  comp_t comp_expected[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;
  logic in_stall_q = 1'b0;

  env_sensor_compensation_unit DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] sra32(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] ext32(logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [63:0] quot64(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic comp_t compensate(reading_t r);
    comp_t c;
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, v1, v2, fine, u, left, inner, right, q;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] x1, x2, p, s, y1, y2;
    t1 = {16'd0, k_temp[15:0]};
    t2 = {{16{k_temp[31]}}, k_temp[31:16]};
    t3 = {{16{k_temp[47]}}, k_temp[47:32]};
    p1 = {48'd0, k_plow[15:0]};
    p2 = {{48{k_plow[31]}}, k_plow[31:16]};
    p3 = {{48{k_plow[47]}}, k_plow[47:32]};
    p4 = {{48{k_plow[63]}}, k_plow[63:48]};
    p5 = {{48{k_phigh[15]}}, k_phigh[15:0]};
    p6 = {{48{k_phigh[31]}}, k_phigh[31:16]};
    p7 = {{48{k_phigh[47]}}, k_phigh[47:32]};
    p8 = {{48{k_phigh[63]}}, k_phigh[63:48]};
    p9 = {{48{k_misc[15]}}, k_misc[15:0]};
    h1 = {24'd0, k_misc[23:16]};
    h2 = {{16{k_misc[39]}}, k_misc[39:24]};
    h3 = {24'd0, k_misc[47:40]};
    h6 = {{24{k_misc[55]}}, k_misc[55:48]};
    h4 = {{16{k_hum[15]}}, k_hum[15:0]};
    h5 = {{16{k_hum[31]}}, k_hum[31:16]};

    a = {12'd0, r.t} >> 3;
    a = a - (t1 << 1);
    v1 = sra32(a * t2, 11);
    b = ({12'd0, r.t} >> 4) - t1;
    v2 = sra32(sra32(b * b, 12) * t3, 14);
    fine = v1 + v2;
    c.temp = sra32(fine * 32'd5 + 32'd128, 8);

    x1 = ext32(fine) - 64'd128000;
    x2 = x1 * x1 * p6;
    x2 = x2 + ((x1 * p5) << 17);
    x2 = x2 + (p4 << 35);
    x1 = sra64(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
    x1 = sra64(((64'd1 << 47) + x1) * p1, 33);
    c.press = '0;
    c.inv = 1'b0;
    if (x1 == 0) begin
      c.inv = 1'b1;
    end else begin
      p = 64'd1048576 - {44'd0, r.p};
      p = ((p << 31) - x2) * 64'd3125;
      p = quot64(p, x1);
      s = sra64(p, 13);
      y1 = sra64(p9 * s * s, 25);
      y2 = sra64(p8 * p, 19);
      p = sra64(p + y1 + y2, 8) + (p7 << 4);
      c.press = p[31:0];
    end

    u = fine - 32'd76800;
    left = sra32(({16'd0, r.h} << 14) - (h4 << 20) - (h5 * u) + 32'd16384, 15);
    inner = sra32(u * h6, 10) * (sra32(u * h3, 11) + 32'd32768);
    right = sra32((sra32(inner, 10) + 32'd2097152) * h2 + 32'd8192, 14);
    u = left * right;
    q = sra32(u, 15);
    u = u - sra32(sra32(q * q, 7) * h1, 4);
    if ($signed(u) < 0) u = 0;
    if ($signed(u) > 419430400) u = 32'd419430400;
    c.hum = u[28:12];
    return c;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_TEMP:       k_temp = val & 64'hFFFF_FFFF_FFFF;
      CFG_PRESS_LOW:  k_plow = val;
      CFG_PRESS_HIGH: k_phigh = val;
      CFG_MISC:       k_misc = val & 64'h00FF_FFFF_FFFF_FFFF;
      CFG_HUM:        k_hum = val & 64'hFFFF_FFFF;
      default: ;
    endcase
  endtask

  // all zero, typical datasheet calibration, all ones, extremes, or random sets
  task automatic load_coeffs(int mode);
    logic [63:0] rnd [5];
    for (int i = 0; i < 5; i++) rnd[i] = {$urandom, $urandom};
    case (mode)
      0: begin
        write_reg(CFG_TEMP, 64'h0);
        write_reg(CFG_PRESS_LOW, 64'h0);
        write_reg(CFG_PRESS_HIGH, 64'h0);
        write_reg(CFG_MISC, 64'h0);
        write_reg(CFG_HUM, 64'h0);
      end
      1: begin
        write_reg(CFG_TEMP, {16'd0, 16'd50, 16'd26435, 16'd27504});
        write_reg(CFG_PRESS_LOW, {16'd8004, 16'hD0BF, 16'hD0BF ^ 16'h0, 16'd36477} &
                  64'hFFFF_0000_FFFF_FFFF | {16'd0, 16'd3024, 32'd0});
        write_reg(CFG_PRESS_HIGH, {16'hC0B8, 16'd15500, 16'hFFF9, 16'hFF2E});
        write_reg(CFG_MISC, {8'd0, 8'd30, 8'd0, 16'd362, 8'd75, 16'd6000});
        write_reg(CFG_HUM, {32'd0, 16'd50, 16'd313});
      end
      2: begin
        write_reg(CFG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_MISC, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_HUM, 64'hFFFF_FFFF_FFFF_FFFF);
      end
      3: begin
        write_reg(CFG_TEMP, {16'd0, 16'h8000, 16'h8000, 16'h8000});
        write_reg(CFG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
        write_reg(CFG_PRESS_HIGH, 64'h7FFF_7FFF_8000_7FFF);
        write_reg(CFG_MISC, 64'h0080_FF7F_FF80_8000);
        write_reg(CFG_HUM, 64'h7FFF_8000);
      end
      default: begin
        write_reg(CFG_TEMP, {16'd0, 16'd27000 + rnd[0][15:0] % 16'd2000,
                  rnd[0][31:16] | 16'h4000 & 16'h7FFF,
                  16'd27000 + rnd[0][47:32] % 16'd2000});
        write_reg(CFG_PRESS_LOW, rnd[1]);
        write_reg(CFG_PRESS_HIGH, rnd[2]);
        write_reg(CFG_MISC, rnd[3]);
        write_reg(CFG_HUM, rnd[4]);
      end
    endcase
  endtask

  function automatic reading_t pick_reading(int kind);
    reading_t r;
    case (kind)
      0: begin r.p = '0; r.t = '0; r.h = '0; end
      1: begin r.p = '1; r.t = '1; r.h = '1; end
      default: begin
        r.p = 20'($urandom);
        r.t = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(400000, 600000));
        r.h = 16'($urandom);
      end
    endcase
    return r;
  endfunction

  task automatic wait_drained;
    while (pending.size() != 0 || comp_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver: bursts of transfers with random gaps, and output stall patterns
  always @(negedge clk) begin
    if (!rst) begin
      // hold a stalled transfer until it is taken
      if (!in_valid || !in_stall_q) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_valid <= 1'b1;
          raw_pressure <= pending[0].p;
          raw_temperature <= pending[0].t;
          raw_humidity <= pending[0].h;
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (stall_phase % 7) < 3;
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
      stall_phase++;
      if (stall_phase % 300 == 0) stall_mode = $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    in_stall_q <= in_valid && in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        comp_expected.push_back(compensate(pending.pop_front()));
      end
      if (out_valid && !out_stall) begin
        if (comp_expected.size() == 0) begin
          $display("%0t: result with none expected: temp %h press %h hum %h inv %b",
                   $time, temperature_centi, pressure_q24_8, humidity_q22_10,
                   pressure_invalid);
          errors++;
        end else begin
          comp_t e;
          e = comp_expected.pop_front();
          if (temperature_centi !== e.temp) begin
            $display("%0t: temperature_centi expected %h actual %h", $time, e.temp,
                     temperature_centi);
            errors++;
          end
          if (pressure_q24_8 !== e.press) begin
            $display("%0t: pressure_q24_8 expected %h actual %h", $time, e.press,
                     pressure_q24_8);
            errors++;
          end
          if (humidity_q22_10 !== e.hum) begin
            $display("%0t: humidity_q22_10 expected %h actual %h", $time, e.hum,
                     humidity_q22_10);
            errors++;
          end
          if (pressure_invalid !== e.inv) begin
            $display("%0t: pressure_invalid expected %b actual %b", $time, e.inv,
                     pressure_invalid);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    k_temp = '0; k_plow = '0; k_phigh = '0; k_misc = '0; k_hum = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // reset coefficients: divisor is zero, so every pressure is flagged
    pending.push_back(pick_reading(0));
    pending.push_back(pick_reading(1));
    wait_drained();
    for (int phase = 1; phase <= 8; phase++) begin
      load_coeffs(phase > 4 ? 4 : phase);
      if (phase <= 3) begin
        pending.push_back(pick_reading(0));
        pending.push_back(pick_reading(1));
        for (int i = 0; i < 6; i++) pending.push_back(pick_reading(2));
      end else begin
        for (int i = 0; i < 280; i++) pending.push_back(pick_reading(2));
      end
      wait_drained();
    end
    load_coeffs(0);
    for (int i = 0; i < 20; i++) pending.push_back(pick_reading(2));
    wait_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+sv
sv/escu_pkg.sv
sv/escu_front.sv
sv/escu_queue.sv
sv/escu_div.sv
sv/escu_back.sv
sv/env_sensor_compensation_unit.sv
tb/env_sensor_compensation_unit_test.sv
